// ----- hw/rtl/u8dec_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers of the UTF-8 string decoder.
package u8dec_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [1:0] ST_CHAR   = 2'd0;
  localparam logic [1:0] ST_END    = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  localparam logic [20:0] SURR_LO = 21'h00D800;
  localparam logic [20:0] SURR_HI = 21'h00DFFF;
  localparam logic [20:0] REPL_CP = 21'h00FFFD;

  // Byte after classification by the front end.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       is_zero;
    logic       is_cont;
    logic [2:0] lead_len;   // 0 when the byte cannot start a sequence
    logic [6:0] lead_bits;
  } class_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [1:0]  status;
    logic [15:0] char_count;
    logic        last;
  } result_t;

  function automatic logic [20:0] seq_min(input logic [2:0] len);
    logic [20:0] v;
    case (len)
      3'd2:    v = 21'h000080;
      3'd3:    v = 21'h000800;
      3'd4:    v = 21'h010000;
      default: v = 21'h000000;
    endcase
    return v;
  endfunction

  function automatic logic [20:0] seq_max(input logic [2:0] len);
    logic [20:0] v;
    case (len)
      3'd1:    v = 21'h00007F;
      3'd2:    v = 21'h0007FF;
      3'd3:    v = 21'h00FFFF;
      3'd4:    v = 21'h10FFFF;
      default: v = 21'h000000;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/utf8_string_decoder.sv -----
`timescale 1ns / 1ps
// Top level of the UTF-8 string decoder.
// Input side is a queue write port: a byte transaction completes when push is
// high and full is low; string_start marks the first byte of a new string.
// Result side is a queue read port: the oldest result sits on code_point,
// status, char_count and last while empty is low, and leaves on pop.
// The cfg channel writes the character limit (cfg_valid with cfg_ready,
// which is always high); write it only while the block is idle.
// An accepted byte is classified and written into a 2-entry queue; the back
// end decodes it from the queue head while the result queue has room and
// writes its result (if any) into the 2-entry result queue read by the ports.
// One byte per cycle is sustained with no gap while results are popped.
// When the receiver stops popping, the 2-entry result queue fills, the back
// end halts, then the input queue fills and full rises; nothing is dropped.
// Reset empties both queues, clears the sequence state, count and limit.
module utf8_string_decoder #(
  parameter int COUNT_BITS = u8dec_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        string_start,
  output logic        empty,
  input  logic        pop,
  output logic [20:0] code_point,
  output logic [1:0]  status,
  output logic [15:0] char_count,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int CW = $bits(u8dec_pkg::class_t);
  localparam int RW = $bits(u8dec_pkg::result_t);

  u8dec_pkg::class_t  f_data;
  u8dec_pkg::class_t  q_data;
  u8dec_pkg::result_t r_wr;
  u8dec_pkg::result_t r_rd;
  logic               f_push;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;
  logic               r_push;
  logic               r_full;

  assign cfg_ready = 1'b1;

  u8dec_front u_front (
    .push         (push),
    .in_byte      (in_byte),
    .string_start (string_start),
    .q_full       (q_full),
    .full         (full),
    .q_push       (f_push),
    .q_data       (f_data)
  );

  u8dec_fifo #(
    .WIDTH (CW),
    .DEPTH (u8dec_pkg::QUEUE_DEPTH)
  ) u_class_q (
    .clk     (clk),
    .rst     (rst),
    .push    (f_push),
    .wr_data (f_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  u8dec_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .r_full    (r_full),
    .r_push    (r_push),
    .r_data    (r_wr)
  );

  u8dec_fifo #(
    .WIDTH (RW),
    .DEPTH (u8dec_pkg::QUEUE_DEPTH)
  ) u_result_q (
    .clk     (clk),
    .rst     (rst),
    .push    (r_push),
    .wr_data (r_wr),
    .full    (r_full),
    .pop     (pop),
    .rd_data (r_rd),
    .empty   (empty)
  );

  assign code_point = r_rd.code_point;
  assign status     = r_rd.status;
  assign char_count = r_rd.char_count;
  assign last       = r_rd.last;

endmodule

// ----- hw/rtl/u8dec_fifo.sv -----
`timescale 1ns / 1ps
// Small register-based queue with push/full and pop/empty sides.
module u8dec_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- hw/rtl/u8dec_front.sv -----
`timescale 1ns / 1ps
// Front end: takes input bytes and classifies them for the decode stage.
module u8dec_front (
  input  logic               push,
  input  logic [7:0]         in_byte,
  input  logic               string_start,
  input  logic               q_full,
  output logic               full,
  output logic               q_push,
  output u8dec_pkg::class_t  q_data
);

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_data.data      = in_byte;
    q_data.start     = string_start;
    q_data.is_zero   = (in_byte == 8'h00);
    q_data.is_cont   = (in_byte[7:6] == 2'b10);
    q_data.lead_len  = 3'd0;
    q_data.lead_bits = 7'd0;
    if (!in_byte[7]) begin
      q_data.lead_len  = 3'd1;
      q_data.lead_bits = in_byte[6:0];
    end else if (in_byte[7:5] == 3'b110) begin
      q_data.lead_len  = 3'd2;
      q_data.lead_bits = {2'b00, in_byte[4:0]};
    end else if (in_byte[7:4] == 4'b1110) begin
      q_data.lead_len  = 3'd3;
      q_data.lead_bits = {3'b000, in_byte[3:0]};
    end else if (in_byte[7:3] == 5'b11110) begin
      q_data.lead_len  = 3'd4;
      q_data.lead_bits = {4'b0000, in_byte[2:0]};
    end
  end

endmodule

// ----- hw/rtl/u8dec_back.sv -----
`timescale 1ns / 1ps
// Back end: sequence state, validation, character count and result build.
module u8dec_back #(
  parameter int COUNT_BITS = u8dec_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [15:0]        cfg_data,
  input  logic               q_empty,
  input  u8dec_pkg::class_t  q_data,
  output logic               q_pop,
  input  logic               r_full,
  output logic               r_push,
  output u8dec_pkg::result_t r_data
);

  localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [15:0]           max_chars;
  logic [20:0]           acc;
  logic [2:0]            seq_len;
  logic [1:0]            rem;
  logic [COUNT_BITS-1:0] count;
  logic                  stopped;

  logic [20:0]           acc_next;
  logic [2:0]            seq_len_next;
  logic [1:0]            rem_next;
  logic [COUNT_BITS-1:0] count_next;
  logic                  stopped_next;

  logic                  take;
  logic                  emit;
  logic [20:0]           res_cp;
  logic [1:0]            res_status;
  logic                  res_last;
  logic                  do_finish;
  logic                  limit_met;
  logic [CMP_W-1:0]      cnt_ext;

  assign take  = !q_empty && !r_full;
  assign q_pop = take;

  always_comb begin
    acc_next     = acc;
    seq_len_next = seq_len;
    rem_next     = rem;
    count_next   = count;
    stopped_next = stopped;
    emit         = 1'b0;
    res_cp       = '0;
    res_status   = u8dec_pkg::ST_CHAR;
    res_last     = 1'b0;
    do_finish    = 1'b0;
    limit_met    = 1'b0;
    if (take) begin
      if (q_data.start) begin
        acc_next     = '0;
        seq_len_next = '0;
        rem_next     = '0;
        count_next   = '0;
        stopped_next = 1'b0;
      end
      if (!stopped_next) begin
        limit_met = (max_chars != 16'd0) &&
                    (CMP_W'(count_next) >= CMP_W'(max_chars));
        if (rem_next != 2'd0) begin
          if (!q_data.is_cont) begin
            emit       = 1'b1;
            res_status = u8dec_pkg::ST_REJECT;
            res_last   = 1'b1;
          end else begin
            acc_next  = {acc_next[14:0], q_data.data[5:0]};
            rem_next  = rem_next - 2'd1;
            do_finish = (rem_next == 2'd0);
          end
        end else if (limit_met || q_data.is_zero) begin
          emit       = 1'b1;
          res_status = u8dec_pkg::ST_END;
          res_last   = 1'b1;
        end else if (q_data.lead_len == 3'd0) begin
          emit       = 1'b1;
          res_status = u8dec_pkg::ST_REJECT;
          res_last   = 1'b1;
        end else begin
          acc_next     = {14'd0, q_data.lead_bits};
          seq_len_next = q_data.lead_len;
          rem_next     = 2'(q_data.lead_len - 3'd1);
          do_finish    = (rem_next == 2'd0);
        end
        if (do_finish) begin
          emit = 1'b1;
          if (acc_next < u8dec_pkg::seq_min(seq_len_next) ||
              acc_next > u8dec_pkg::seq_max(seq_len_next) ||
              (acc_next >= u8dec_pkg::SURR_LO && acc_next <= u8dec_pkg::SURR_HI) ||
              acc_next == u8dec_pkg::REPL_CP) begin
            res_status = u8dec_pkg::ST_REJECT;
            res_last   = 1'b1;
          end else begin
            if (!(&count_next)) begin
              count_next = count_next + 1'b1;
            end
            res_cp       = acc_next;
            res_status   = u8dec_pkg::ST_CHAR;
            res_last     = (max_chars != 16'd0) &&
                           (CMP_W'(count_next) >= CMP_W'(max_chars));
            acc_next     = '0;
            seq_len_next = '0;
            rem_next     = '0;
          end
        end
        if (emit && res_last) begin
          stopped_next = 1'b1;
          acc_next     = '0;
          seq_len_next = '0;
          rem_next     = '0;
        end
      end
    end
  end

  assign cnt_ext = CMP_W'(count_next);
  assign r_push  = emit;

  always_comb begin
    r_data.code_point = res_cp;
    r_data.status     = res_status;
    r_data.last       = res_last;
    r_data.char_count = (cnt_ext > CMP_W'(16'hFFFF)) ? 16'hFFFF : cnt_ext[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars <= '0;
      acc       <= '0;
      seq_len   <= '0;
      rem       <= '0;
      count     <= '0;
      stopped   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_chars <= cfg_data;
      end
      acc     <= acc_next;
      seq_len <= seq_len_next;
      rem     <= rem_next;
      count   <= count_next;
      stopped <= stopped_next;
    end
  end

endmodule

// ----- hw/rtl/u8dec_checker.sv -----
`timescale 1ns / 1ps
// Port-level assertions for the UTF-8 string decoder, bound to the top level.
module u8dec_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [20:0] code_point,
  input logic [1:0]  status,
  input logic        last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(code_point) && $stable(status) &&
                       $stable(last))
    else $error("pending result changed while stalled");

  a_final_form: assert property (@(posedge clk) disable iff (rst)
    !empty && status != u8dec_pkg::ST_CHAR |->
      last && code_point == 21'd0 &&
      (status == u8dec_pkg::ST_END || status == u8dec_pkg::ST_REJECT))
    else $error("end or reject result malformed");

  a_valid_cp: assert property (@(posedge clk) disable iff (rst)
    !empty && status == u8dec_pkg::ST_CHAR |->
      code_point <= 21'h10FFFF && code_point != u8dec_pkg::REPL_CP &&
      (code_point < u8dec_pkg::SURR_LO || code_point > u8dec_pkg::SURR_HI))
    else $error("decoded code point outside the accepted set");

endmodule

bind utf8_string_decoder u8dec_checker u_chk (.*);
